/* design/ccc_pkg.sv */
// Package for the calendar clock counter: beat types, function codes,
// counter limits and the month length and day-of-year tables.
// No dependencies; ccc_in_reg, ccc_core and calendar_clock_counter import it.
`timescale 1ns / 1ps

package ccc_pkg;

   // Function codes carried in the request tuser.
   localparam logic FUNC_ELAPSE = 1'b0;
   localparam logic FUNC_SET    = 1'b1;

   localparam int REM_W = 26;   // remaining-time counter, two's complement
   localparam int SUB_W = 27;   // one guard bit for the subtract

   localparam logic signed [SUB_W-1:0] REM_MIN = -27'sd33554432;

   localparam logic [23:0] MINUTE_LENGTH_RESET = 24'd61440;

   localparam logic [6:0] MINUTES_PER_HOUR = 7'd60;
   localparam logic [5:0] HOURS_PER_DAY    = 6'd24;
   localparam logic [4:0] MONTHS_PER_YEAR  = 5'd12;

   typedef struct packed {
      logic        func;
      logic [19:0] delta;
      logic [5:0]  set_minute;
      logic [4:0]  set_hour;
      logic [4:0]  set_day;
      logic [3:0]  set_month;
      logic [15:0] set_year;
   } req_item_type;

   typedef struct packed {
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [15:0] year;
      logic [8:0]  day_of_year;
      logic [10:0] minute_of_day;
      logic        advanced;
      logic        load_error;
   } rsp_item_type;

   // Days in a month; zero for a month code that names no month.
   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    days = 5'd30;
         4'd2:                                       days = leap ? 5'd29 : 5'd28;
         default:                                    days = 5'd0;
      endcase
      return days;
   endfunction

   // Days in the months before the given one.
   function automatic logic [8:0] days_before(input logic [3:0] month, input logic leap);
      logic [8:0] days;
      case (month)
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      if (leap && (month > 4'd2)) begin
         days = days + 9'd1;
      end
      return days;
   endfunction

endpackage

/* design/ccc_in_reg.sv */
// Input register of the calendar clock counter: holds one request beat.
// Depends on ccc_pkg for the request beat type.
`timescale 1ns / 1ps

module ccc_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  ccc_pkg::req_item_type in_item,
   input  logic                 drain,      // downstream takes the held beat
   output logic                 held_valid,
   output ccc_pkg::req_item_type held_item
);
   import ccc_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign in_ready   = !valid_ff || drain;
   assign valid_in   = in_ready ? in_valid : valid_ff;
   assign held_valid = valid_ff;
   assign held_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

/* design/ccc_core.sv */
// Calendar state and update logic: remaining-time counter, minute rollover
// cascade, set-item check and day-of-year load. Depends on ccc_pkg.
`timescale 1ns / 1ps

module ccc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  ccc_pkg::req_item_type item,
   input  logic                  csr_we,
   input  logic [23:0]           csr_wdata,
   output ccc_pkg::rsp_item_type result
);
   import ccc_pkg::*;

   logic [23:0]      minlen_ff;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [5:0]       min_ff, min_in;
   logic [4:0]       hour_ff, hour_in;
   logic [4:0]       day_ff, day_in;
   logic [3:0]       month_ff, month_in;
   logic [15:0]      year_ff, year_in;
   logic [8:0]       doy_ff, doy_in;

   logic signed [SUB_W-1:0] sub_r, sat_r, add_r;
   logic        tick;
   logic [6:0]  min_p1;
   logic [5:0]  hour_p1;
   logic [5:0]  day_p1;
   logic [4:0]  month_p1;
   logic        wrap_min, wrap_hour, wrap_day, wrap_month;
   logic [5:0]  st_min;
   logic [4:0]  st_hour, st_day;
   logic [3:0]  st_month;
   logic [15:0] st_year;
   logic [8:0]  st_doy;
   logic        set_leap, set_bad;
   logic [4:0]  set_len;
   logic [8:0]  set_doy;
   logic        advanced, load_error;

   // Counter: subtract, saturate low, add one minute back on expiry.
   always_comb begin
      sub_r = $signed({rem_ff[REM_W-1], rem_ff}) - $signed({7'd0, item.delta});
      sat_r = (sub_r < REM_MIN) ? REM_MIN : sub_r;
      tick  = sat_r[SUB_W-1] || (sat_r == '0);
      add_r = sat_r + $signed({3'd0, minlen_ff});
   end

   // One-minute step with carries through hour, day, month and year.
   always_comb begin
      min_p1     = {1'b0, min_ff} + 7'd1;
      hour_p1    = {1'b0, hour_ff} + 6'd1;
      day_p1     = {1'b0, day_ff} + 6'd1;
      month_p1   = {1'b0, month_ff} + 5'd1;
      wrap_min   = min_p1 >= MINUTES_PER_HOUR;
      wrap_hour  = wrap_min && (hour_p1 >= HOURS_PER_DAY);
      wrap_day   = wrap_hour &&
                   (day_p1 > {1'b0, month_days(month_ff, year_ff[1:0] == 2'd0)});
      wrap_month = wrap_day && (month_p1 > MONTHS_PER_YEAR);

      st_min   = wrap_min ? 6'd0 : min_p1[5:0];
      st_hour  = hour_ff;
      st_day   = day_ff;
      st_month = month_ff;
      st_year  = year_ff;
      st_doy   = doy_ff;
      if (wrap_min) begin
         st_hour = wrap_hour ? 5'd0 : hour_p1[4:0];
      end
      if (wrap_hour) begin
         st_doy = doy_ff + 9'd1;
         st_day = wrap_day ? 5'd1 : day_p1[4:0];
      end
      if (wrap_day) begin
         st_month = wrap_month ? 4'd1 : month_p1[3:0];
      end
      if (wrap_month) begin
         st_doy  = 9'd1;
         st_year = year_ff + 16'd1;
      end
   end

   // Set item check and ordinal day.
   always_comb begin
      set_leap = item.set_year[1:0] == 2'd0;
      set_len  = month_days(item.set_month, set_leap);
      set_bad  = (item.set_minute >= MINUTES_PER_HOUR[5:0]) ||
                 (item.set_hour >= HOURS_PER_DAY[4:0]) ||
                 (item.set_day == 5'd0) || (item.set_day > set_len);
      set_doy  = days_before(item.set_month, set_leap) + {4'd0, item.set_day};
   end

   always_comb begin
      rem_in     = rem_ff;
      min_in     = min_ff;
      hour_in    = hour_ff;
      day_in     = day_ff;
      month_in   = month_ff;
      year_in    = year_ff;
      doy_in     = doy_ff;
      advanced   = 1'b0;
      load_error = 1'b0;
      if (item.func == FUNC_ELAPSE) begin
         rem_in = tick ? add_r[REM_W-1:0] : sat_r[REM_W-1:0];
         if (tick) begin
            min_in   = st_min;
            hour_in  = st_hour;
            day_in   = st_day;
            month_in = st_month;
            year_in  = st_year;
            doy_in   = st_doy;
            advanced = 1'b1;
         end
      end else if (set_bad) begin
         load_error = 1'b1;
      end else begin
         rem_in   = {2'd0, minlen_ff};
         min_in   = item.set_minute;
         hour_in  = item.set_hour;
         day_in   = item.set_day;
         month_in = item.set_month;
         year_in  = item.set_year;
         doy_in   = set_doy;
         advanced = 1'b1;
      end
   end

   always_comb begin
      result.minute        = min_in;
      result.hour          = hour_in;
      result.day           = day_in;
      result.month         = month_in;
      result.year          = year_in;
      result.day_of_year   = doy_in;
      // hour * 60 = hour * 64 - hour * 4
      result.minute_of_day = ({6'd0, hour_in} << 6) - ({6'd0, hour_in} << 2)
                             + {5'd0, min_in};
      result.advanced      = advanced;
      result.load_error    = load_error;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         minlen_ff <= MINUTE_LENGTH_RESET;
         rem_ff    <= '0;
         min_ff    <= 6'd0;
         hour_ff   <= 5'd0;
         day_ff    <= 5'd1;
         month_ff  <= 4'd1;
         year_ff   <= 16'd0;
         doy_ff    <= 9'd1;
      end else begin
         if (csr_we) begin
            minlen_ff <= csr_wdata;
         end
         if (fire) begin
            rem_ff   <= rem_in;
            min_ff   <= min_in;
            hour_ff  <= hour_in;
            day_ff   <= day_in;
            month_ff <= month_in;
            year_ff  <= year_in;
            doy_ff   <= doy_in;
         end
      end
   end

endmodule

/* design/calendar_clock_counter.sv */
// Calendar clock counter: an accepted request beat passes the input register,
// then the result register (its response beat); throughput one beat per cycle
// unless rsp_tready stalls, set by the combinational state update in ccc_core.
// Synchronous active-high reset clears both valid flags, sets minute_length
// to 61440 and the calendar to 00:00 on day 1 of month 1, year 0.
// Depends on ccc_pkg, ccc_in_reg and ccc_core.
`timescale 1ns / 1ps

module calendar_clock_counter (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: delta[19:0], set_minute[25:20], set_hour[30:26], set_day[35:31],
   //        set_month[39:36], set_year[55:40]
   input  logic [55:0] req_tdata,
   // tuser: func[0]
   input  logic        req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: minute[5:0], hour[10:6], day[15:11], month[19:16], year[35:20],
   //        day_of_year[44:36], minute_of_day[55:45]
   output logic [55:0] rsp_tdata,
   // tuser: advanced[0], load_error[1]
   output logic [1:0]  rsp_tuser,
   // Configuration: minute_length.
   input  logic        csr_we,
   input  logic [23:0] csr_wdata
);
   import ccc_pkg::*;

   req_item_type req_item;
   req_item_type held_item;
   rsp_item_type result;
   rsp_item_type rsp_ff;
   logic         held_valid;
   logic         advance;
   logic         fire;
   logic         rsp_valid_ff;

   // Unpack the request beat into its fields.
   always_comb begin
      req_item.func       = req_tuser;
      req_item.delta      = req_tdata[19:0];
      req_item.set_minute = req_tdata[25:20];
      req_item.set_hour   = req_tdata[30:26];
      req_item.set_day    = req_tdata[35:31];
      req_item.set_month  = req_tdata[39:36];
      req_item.set_year   = req_tdata[55:40];
   end

   // The pipeline moves whenever the result register is empty or being
   // drained. A held request beat is processed and its result registered in
   // the same cycle, so the next beat always sees the updated calendar.
   assign advance = !rsp_valid_ff || rsp_tready;
   assign fire    = held_valid && advance;

   ccc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .drain      (advance),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   ccc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (held_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .result    (result)
   );

   // Result register; it holds a beat until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= held_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.minute_of_day, rsp_ff.day_of_year, rsp_ff.year,
                        rsp_ff.month, rsp_ff.day, rsp_ff.hour, rsp_ff.minute};
   assign rsp_tuser  = {rsp_ff.load_error, rsp_ff.advanced};

endmodule

/* design/ccc_checker.sv */
// Port-level checks for the calendar clock counter, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module ccc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A stalled response beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

   // No response beat right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A rejected set beat never reports an advance.
   a_error_no_adv: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("load error together with advance");

   // Minute of day matches hour and minute.
   a_mod: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[55:45] ==
         ({6'd0, rsp_tdata[10:6]} * 11'd60 + {5'd0, rsp_tdata[5:0]}))
      else $error("minute of day mismatch");

   // Month stays in range, day is nonzero and minute stays within 0 to 59.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[19:16] != 4'd0 && rsp_tdata[19:16] <= 4'd12 &&
                     rsp_tdata[15:11] != 5'd0 && rsp_tdata[5:0] <= 6'd59)
      else $error("calendar field out of range");

endmodule

bind calendar_clock_counter ccc_checker u_ccc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
